// ===== design/fvn_pkg.sv =====
// fvn_pkg: constants shared by the fractal value noise datapath
// no dependencies
package fvn_pkg;

  localparam int unsigned START_PITCH_LOG2_DEF = 6;
  localparam int unsigned CNT_W       = 3;
  localparam logic [CNT_W-1:0] CNT_RESET = 3'd4;
  localparam logic [31:0] AXIS_OFFSET = 32'd1000000;
  localparam logic [31:0] HASH_MUL    = 32'd1664525;
  localparam logic [31:0] HASH_ADD    = 32'd1013904223;
  localparam int unsigned LANE_LAT    = 9;
  localparam int unsigned FRAC_W      = 16;
  localparam int unsigned W_W         = 17;
  localparam int unsigned OUT_W       = 17;

endpackage

// ===== design/fvn_if.sv =====
// fvn_in_if / fvn_out_if: valid/ready channels of the noise block
// depends on nothing
interface fvn_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] coord_x;
  logic signed [31:0] coord_y;
  logic signed [31:0] coord_z;
  modport source (output valid, coord_x, coord_y, coord_z, input ready);
  modport sink   (input valid, coord_x, coord_y, coord_z, output ready);
endinterface

interface fvn_out_if;
  logic        valid;
  logic        ready;
  logic [16:0] noise_value;
  modport source (output valid, noise_value, input ready);
  modport sink   (input valid, noise_value, output ready);
endinterface

// ===== design/fractal_value_noise_3d_top.sv =====
// fractal_value_noise_3d_top: multi-octave 3D value noise, one point per cycle when not stalled
// depends on fvn_pkg, fvn_if, fvn_octave
// Accepts one Q16.16 point per clock while the pipeline is not held, and delivers one
// Q1.16 noise sample per point, in order. All octave lanes run in parallel and the whole
// pipeline advances together, holding when the output register
// is full and not taken. octave_count (reset 4, saturated at START_PITCH_LOG2+1) must be
// written only while no points are in flight.
module fractal_value_noise_3d_top #(
  parameter int unsigned START_PITCH_LOG2 = fvn_pkg::START_PITCH_LOG2_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [fvn_pkg::CNT_W-1:0] cfg_data_i,
  fvn_in_if.sink                   in_i,
  fvn_out_if.source                out_o
);
  import fvn_pkg::*;

  localparam int unsigned LANES = START_PITCH_LOG2 + 1;

  logic [CNT_W-1:0]    cnt_q;
  logic [LANE_LAT:0]   vld_q;
  logic                out_vld_q;
  logic [OUT_W-1:0]    out_q;
  logic [2:0][31:0]    u_q;
  logic [2:0][15:0]    frac_q;
  logic [LANES-1:0][15:0] lane_val;
  logic [OUT_W-1:0]    sum_d;
  logic                en;

  assign en = !out_vld_q || out_o.ready;
  assign in_i.ready = en;

  always_comb begin
    sum_d = '0;
    for (int i = 0; i < LANES; i++) begin
      if (i < int'(cnt_q)) sum_d = sum_d + OUT_W'(lane_val[i] >> i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= CNT_RESET;
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (cfg_we_i) cnt_q <= cfg_data_i;
      if (en) begin
        vld_q     <= {vld_q[LANE_LAT-1:0], in_i.valid};
        out_vld_q <= vld_q[LANE_LAT];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      u_q[0]    <= {{16{in_i.coord_x[31]}}, in_i.coord_x[31:16]} + AXIS_OFFSET;
      u_q[1]    <= {{16{in_i.coord_y[31]}}, in_i.coord_y[31:16]} + AXIS_OFFSET;
      u_q[2]    <= {{16{in_i.coord_z[31]}}, in_i.coord_z[31:16]} + AXIS_OFFSET;
      frac_q[0] <= in_i.coord_x[15:0];
      frac_q[1] <= in_i.coord_y[15:0];
      frac_q[2] <= in_i.coord_z[15:0];
      out_q     <= sum_d;
    end
  end

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    fvn_octave #(.LG(START_PITCH_LOG2 - i)) u_oct (
      .clk_i  (clk_i),
      .en_i   (en),
      .u_i    (u_q),
      .frac_i (frac_q),
      .val_o  (lane_val[i])
    );
  end

  assign out_o.valid       = out_vld_q;
  assign out_o.noise_value = out_q;
endmodule

// ===== design/fvn_hash.sv =====
// fvn_hash: five-stage pipelined corner hash, low 16 bits out
// depends on nothing
module fvn_hash (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  input  logic [31:0] c_i,
  output logic [15:0] val_o
);
  logic [31:0] a1_q, b1_q, c1_q;
  logic [31:0] a2_q, b2_q, c2_q;
  logic [31:0] a3_q, b3_q, c3_q;
  logic [31:0] m4_q, a4_q;
  logic [15:0] b4_q, c4_q;
  logic [15:0] r5_q;
  logic [31:0] ax, bx, cx;
  logic [15:0] s4;

  always_comb begin
    ax = a3_q ^ (a3_q >> 16);
    bx = b3_q ^ (b3_q >> 16);
    cx = c3_q ^ (c3_q >> 16);
    s4 = m4_q[15:0] + a4_q[15:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a1_q <= a_i + b_i * c_i;
      b1_q <= b_i;
      c1_q <= c_i;
      a2_q <= a1_q;
      b2_q <= b1_q + c1_q * a1_q;
      c2_q <= c1_q;
      a3_q <= a2_q;
      b3_q <= b2_q;
      c3_q <= c2_q + a2_q * b2_q;
      m4_q <= bx * cx;
      a4_q <= ax;
      b4_q <= bx[15:0];
      c4_q <= cx[15:0];
      r5_q <= s4 * c4_q + b4_q;
    end
  end

  assign val_o = r5_q;
endmodule

// ===== design/fvn_octave.sv =====
// fvn_octave: one octave lane, lattice snap, smoothstep, eight hashes, trilinear blend
// depends on fvn_pkg and fvn_hash
module fvn_octave #(
  parameter int unsigned LG = 6
) (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [2:0][31:0]          u_i,
  input  logic [2:0][15:0]          frac_i,
  output logic [15:0]               val_o
);
  import fvn_pkg::*;

  localparam logic [31:0] PITCH = 32'(1) << LG;

  function automatic logic [15:0] blend(input logic [15:0] a, input logic [15:0] b,
                                        input logic [W_W-1:0] w);
    logic [33:0] s;
    s = 34'(a * (17'h10000 - w)) + 34'(b * w);
    return s[31:16];
  endfunction

  logic [2:0][1:0][31:0] h_q;
  logic [2:0][15:0]      t_q;
  logic [2:0][15:0]      t2_q;
  logic [6:0][2:0][W_W-1:0] w_q;
  logic [7:0][15:0]      cv;
  logic [3:0][15:0]      bx_q;
  logic [1:0][15:0]      by_q;
  logic [15:0]           v_q;
  logic [2:0][31:0]      c0, c1;
  logic [2:0][15:0]      t;
  logic [2:0][W_W-1:0]   w_d;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      c0[k] = u_i[k] & ~(PITCH - 32'd1);
      c1[k] = c0[k] + PITCH;
      t[k]  = 16'({u_i[k][15:0], frac_i[k]} >> LG);
    end
    for (int k = 0; k < 3; k++) begin
      w_d[k] = W_W'((36'(t2_q[k]) * (36'd196608 - 36'({t_q[k], 1'b0}))) >> 16);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        h_q[k][0] <= c0[k] * HASH_MUL + HASH_ADD;
        h_q[k][1] <= c1[k] * HASH_MUL + HASH_ADD;
        t_q[k]    <= t[k];
        t2_q[k]   <= 16'((32'(t[k]) * 32'(t[k])) >> 16);
      end
      w_q[0] <= w_d;
      for (int s = 1; s < 7; s++) w_q[s] <= w_q[s-1];
      for (int j = 0; j < 4; j++) bx_q[j] <= blend(cv[2*j], cv[2*j+1], w_q[4][0]);
      by_q[0] <= blend(bx_q[0], bx_q[1], w_q[5][1]);
      by_q[1] <= blend(bx_q[2], bx_q[3], w_q[5][1]);
      v_q     <= blend(by_q[0], by_q[1], w_q[6][2]);
    end
  end

  for (genvar n = 0; n < 8; n++) begin : g_corner
    fvn_hash u_hash (
      .clk_i (clk_i),
      .en_i  (en_i),
      .a_i   (h_q[0][n % 2]),
      .b_i   (h_q[1][(n / 2) % 2]),
      .c_i   (h_q[2][n / 4]),
      .val_o (cv[n])
    );
  end

  assign val_o = v_q;
endmodule

// ===== design/fvn_checker.sv =====
// fvn_checker: port-level checks on the noise block, bound to the top level
// depends on fractal_value_noise_3d_top
module fvn_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [16:0] noise_i
);
  a_reset_idle: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_i)
    else $error("output valid during reset");
  a_ready_rule: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_i == (!out_valid_i || out_ready_i))
    else $error("input ready does not follow output stall");
  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output valid dropped while stalled");
  a_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(noise_i))
    else $error("output data changed while stalled");
endmodule

bind fractal_value_noise_3d_top fvn_checker u_fvn_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .noise_i     (out_o.noise_value)
);
